// ----- rtl/ppvf_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and codes for the point to patch view factor block
// no dependencies
package ppvf_pkg;

  localparam int INDEX_BITS  = 20;
  localparam int ACC_W       = 104;  // signed accumulator of the serial multiplier
  localparam int MAG_W       = 66;   // dot products and squared distance
  localparam int RT_W        = 34;   // square root result
  localparam int DEN_W       = 99;   // divisor width
  localparam int Q_W         = 61;   // quotient width
  localparam int T_W         = 97;   // patch dot times inverse pi
  localparam int STEP_W      = 6;
  localparam int CFG_IDX_W   = 2;

  localparam logic [STEP_W-1:0] DIV1_STEPS = STEP_W'(30);
  localparam logic [STEP_W-1:0] DIV2_STEPS = STEP_W'(61);

  localparam logic [30:0]    INV_PI  = 31'd1367130551;
  localparam logic [28:0]    COS_ONE = 29'h1000_0000;
  localparam logic [Q_W-1:0] GV_ONE  = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_B_SQ, ST_B_RT, ST_P_R2, ST_P_RT, ST_P_DA, ST_P_DB,
    ST_P_M1, ST_P_D1, ST_P_M2, ST_P_M3, ST_P_D2, ST_P_M4, ST_FIN
  } state_e;

  typedef struct packed {
    logic start;
    logic clear;
    logic neg;
  } mac_ctl_t;

endpackage

// ----- rtl/point_patch_view_factor_top.sv -----
`timescale 1ns / 1ps
// point to patch view factor: sequencer, operand selection and result register
// depends on ppvf_pkg, ppvf_mac, ppvf_sqrt, ppvf_div
//
//  channel | handshake                  | payload
//  input   | in_valid_i / in_stall_o    | op, pos_x/y/z, vec_x/y/z, patch_area, occluded, patch_index
//  output  | out_valid_o / out_stall_i  | view_factor, contributes, index_out, view_sum
//  config  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one item at a time; every product goes through one shared shift-add multiplier,
// one multiplier bit per cycle, stopping at the operand's top set bit
// body item: three squares plus a square root
// patch item: stops after the facing test when rejected, goes on to the dividers when evaluated
// (six or thirteen products, 34-step square root, 30- and 61-step dividers)
// async active-low reset; the next item is taken while a result waits on out_stall_i
module point_patch_view_factor_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic [31:0]                        pos_x_i,
  input  logic [31:0]                        pos_y_i,
  input  logic [31:0]                        pos_z_i,
  input  logic [31:0]                        vec_x_i,
  input  logic [31:0]                        vec_y_i,
  input  logic [31:0]                        vec_z_i,
  input  logic [31:0]                        patch_area_i,
  input  logic                               occluded_i,
  input  logic [ppvf_pkg::INDEX_BITS-1:0]    patch_index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [31:0]                        view_factor_o,
  output logic                               contributes_o,
  output logic [ppvf_pkg::INDEX_BITS-1:0]    index_out_o,
  output logic [39:0]                        view_sum_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ppvf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);

  ppvf_pkg::state_e state_q, state_d;
  logic [1:0]       k_q, k_d;
  logic             launched_q, launched_d;
  logic             accept;
  logic             out_load;

  // configuration
  logic [30:0] range_limit_q;
  logic        range_en_q;
  logic [31:0] min_area_q;

  // latched item
  logic                            op_q;
  logic [31:0]                     pos_q [3];
  logic [31:0]                     vec_q [3];
  logic [31:0]                     area_q;
  logic                            occl_q;
  logic [ppvf_pkg::INDEX_BITS-1:0] idx_q;

  // body state
  logic [31:0] bp_q [3];
  logic [31:0] bv_q [3];
  logic [31:0] bmag_q;
  logic        bvalid_q;
  logic [39:0] sum_q;

  // intermediates
  logic [ppvf_pkg::MAG_W-1:0] r2_q, da_q, db_q;
  logic [ppvf_pkg::RT_W-1:0]  rmag_q;
  logic [ppvf_pkg::DEN_W-1:0] den_q;
  logic [ppvf_pkg::T_W-1:0]   t_q;
  logic [28:0]                cosi_q;
  logic [ppvf_pkg::Q_W-1:0]   gv_q;
  logic [31:0]                f_q;

  // units
  ppvf_pkg::mac_ctl_t          mac_ctl;
  logic [ppvf_pkg::MAG_W-1:0]  mac_a, mac_b;
  logic                        mac_busy;
  logic [ppvf_pkg::ACC_W-1:0]  acc;
  logic                        sq_start, sq_busy;
  logic [ppvf_pkg::RT_W-1:0]   root;
  logic                        dv_start, dv_busy;
  logic [ppvf_pkg::DEN_W-1:0]  dv_rem;
  logic [ppvf_pkg::Q_W-1:0]    dv_low;
  logic [ppvf_pkg::STEP_W-1:0] dv_steps;
  logic [ppvf_pkg::Q_W-1:0]    q;

  // per-term operands
  logic [32:0] rdiff, r_mag;
  logic        r_neg;
  logic [31:0] vec_mag, bv_mag;
  logic        vec_neg, bv_neg;

  logic                       acc_neg;
  logic [ppvf_pkg::ACC_W-1:0] acc_abs;
  logic [ppvf_pkg::MAG_W-1:0] acc_mag;
  logic                       mac_done, sq_done, dv_done;
  logic                       ok_now, ovf1, ovf2;
  logic [40:0]                sum_wide;
  logic [39:0]                sum_new;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ppvf_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign rdiff   = {bp_q[k_q][31], bp_q[k_q]} - {pos_q[k_q][31], pos_q[k_q]};
  assign r_neg   = rdiff[32];
  assign r_mag   = r_neg ? 33'(~rdiff + 33'd1) : rdiff;
  assign vec_neg = vec_q[k_q][31];
  assign vec_mag = vec_neg ? 32'(~vec_q[k_q] + 32'd1) : vec_q[k_q];
  assign bv_neg  = bv_q[k_q][31];
  assign bv_mag  = bv_neg ? 32'(~bv_q[k_q] + 32'd1) : bv_q[k_q];

  assign acc_neg = acc[ppvf_pkg::ACC_W-1];
  assign acc_abs = acc_neg ? ppvf_pkg::ACC_W'(~acc + 1'b1) : acc;
  assign acc_mag = acc_abs[ppvf_pkg::MAG_W-1:0];

  assign mac_done = launched_q && !mac_busy;
  assign sq_done  = launched_q && !sq_busy;
  assign dv_done  = launched_q && !dv_busy;

  // facing test uses the sign of the body dot just finished
  assign ok_now = bvalid_q && (area_q >= min_area_q) && !occl_q && (r2_q != '0)
                  && (!range_en_q || (rmag_q < ppvf_pkg::RT_W'(range_limit_q)))
                  && acc_neg;

  assign ovf1 = (ppvf_pkg::DEN_W'(da_q[ppvf_pkg::MAG_W-1:2]) >= den_q);
  assign ovf2 = (ppvf_pkg::DEN_W'(t_q[ppvf_pkg::T_W-1:53]) >= den_q);

  assign sum_wide = {1'b0, sum_q} + 41'(f_q);
  assign sum_new  = sum_wide[40] ? '1 : sum_wide[39:0];

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    case (state_q)
      ppvf_pkg::ST_B_SQ: begin
        mac_a = ppvf_pkg::MAG_W'(vec_mag);
        mac_b = ppvf_pkg::MAG_W'(vec_mag);
      end
      ppvf_pkg::ST_P_R2: begin
        mac_a = ppvf_pkg::MAG_W'(r_mag);
        mac_b = ppvf_pkg::MAG_W'(r_mag);
      end
      ppvf_pkg::ST_P_DA: begin
        mac_a = ppvf_pkg::MAG_W'(bv_mag);
        mac_b = ppvf_pkg::MAG_W'(r_mag);
      end
      ppvf_pkg::ST_P_DB: begin
        mac_a = ppvf_pkg::MAG_W'(vec_mag);
        mac_b = ppvf_pkg::MAG_W'(r_mag);
      end
      ppvf_pkg::ST_P_M1: begin
        mac_a = ppvf_pkg::MAG_W'(bmag_q);
        mac_b = ppvf_pkg::MAG_W'(rmag_q);
      end
      ppvf_pkg::ST_P_M2: begin
        mac_a = db_q;
        mac_b = ppvf_pkg::MAG_W'(ppvf_pkg::INV_PI);
      end
      ppvf_pkg::ST_P_M3: begin
        mac_a = r2_q;
        mac_b = ppvf_pkg::MAG_W'(rmag_q);
      end
      ppvf_pkg::ST_P_M4: begin
        mac_a = ppvf_pkg::MAG_W'(gv_q);
        mac_b = ppvf_pkg::MAG_W'(cosi_q);
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  always_comb begin
    if (state_q == ppvf_pkg::ST_P_D1) begin
      dv_rem   = ppvf_pkg::DEN_W'(da_q[ppvf_pkg::MAG_W-1:2]);
      dv_low   = {da_q[1:0], {(ppvf_pkg::Q_W-2){1'b0}}};
      dv_steps = ppvf_pkg::DIV1_STEPS;
    end else begin
      dv_rem   = ppvf_pkg::DEN_W'(t_q[ppvf_pkg::T_W-1:53]);
      dv_low   = {t_q[52:0], 8'b0};
      dv_steps = ppvf_pkg::DIV2_STEPS;
    end
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    launched_d = launched_q;
    mac_ctl    = '0;
    sq_start   = 1'b0;
    dv_start   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ppvf_pkg::ST_IDLE: begin
        if (accept) begin
          state_d    = op_i ? ppvf_pkg::ST_P_R2 : ppvf_pkg::ST_B_SQ;
          k_d        = 2'd0;
          launched_d = 1'b0;
        end
      end
      ppvf_pkg::ST_B_SQ, ppvf_pkg::ST_P_R2, ppvf_pkg::ST_P_DA, ppvf_pkg::ST_P_DB: begin
        if (!launched_q) begin
          mac_ctl.start = 1'b1;
          mac_ctl.clear = (k_q == 2'd0);
          mac_ctl.neg   = (state_q == ppvf_pkg::ST_P_DA) ? (bv_neg ^ r_neg) :
                          (state_q == ppvf_pkg::ST_P_DB) ? (vec_neg ^ r_neg) : 1'b0;
          launched_d    = 1'b1;
        end else if (mac_done) begin
          launched_d = 1'b0;
          if (k_q == 2'd2) begin
            k_d = 2'd0;
            case (state_q)
              ppvf_pkg::ST_B_SQ: state_d = ppvf_pkg::ST_B_RT;
              ppvf_pkg::ST_P_R2: state_d = ppvf_pkg::ST_P_RT;
              ppvf_pkg::ST_P_DA: state_d = ok_now ? ppvf_pkg::ST_P_DB : ppvf_pkg::ST_FIN;
              default:           state_d = ppvf_pkg::ST_P_M1;
            endcase
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      ppvf_pkg::ST_B_RT, ppvf_pkg::ST_P_RT: begin
        if (!launched_q) begin
          sq_start   = 1'b1;
          launched_d = 1'b1;
        end else if (sq_done) begin
          launched_d = 1'b0;
          state_d    = (state_q == ppvf_pkg::ST_B_RT) ? ppvf_pkg::ST_FIN : ppvf_pkg::ST_P_DA;
        end
      end
      ppvf_pkg::ST_P_M1, ppvf_pkg::ST_P_M2, ppvf_pkg::ST_P_M3, ppvf_pkg::ST_P_M4: begin
        if (!launched_q) begin
          mac_ctl.start = 1'b1;
          mac_ctl.clear = 1'b1;
          launched_d    = 1'b1;
        end else if (mac_done) begin
          launched_d = 1'b0;
          case (state_q)
            ppvf_pkg::ST_P_M1: state_d = ppvf_pkg::ST_P_D1;
            ppvf_pkg::ST_P_M2: state_d = ppvf_pkg::ST_P_M3;
            ppvf_pkg::ST_P_M3: state_d = ppvf_pkg::ST_P_D2;
            default:           state_d = ppvf_pkg::ST_FIN;
          endcase
        end
      end
      ppvf_pkg::ST_P_D1, ppvf_pkg::ST_P_D2: begin
        if (!launched_q) begin
          // quotient already past the clamp: skip the division
          if ((state_q == ppvf_pkg::ST_P_D1) ? ovf1 : ovf2) begin
            state_d = (state_q == ppvf_pkg::ST_P_D1) ? ppvf_pkg::ST_P_M2 : ppvf_pkg::ST_P_M4;
          end else begin
            dv_start   = 1'b1;
            launched_d = 1'b1;
          end
        end else if (dv_done) begin
          launched_d = 1'b0;
          state_d    = (state_q == ppvf_pkg::ST_P_D1) ? ppvf_pkg::ST_P_M2 : ppvf_pkg::ST_P_M4;
        end
      end
      ppvf_pkg::ST_FIN: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ppvf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ppvf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ppvf_pkg::ST_IDLE;
      k_q        <= 2'd0;
      launched_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      launched_q <= launched_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_limit_q <= 31'd409600;
      range_en_q    <= 1'b1;
      min_area_q    <= 32'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ppvf_pkg::REG_RANGE_LIMIT: range_limit_q <= cfg_data_i[30:0];
        ppvf_pkg::REG_RANGE_EN:    range_en_q    <= cfg_data_i[0];
        ppvf_pkg::REG_MIN_AREA:    min_area_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // body state and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        bp_q[i] <= '0;
        bv_q[i] <= '0;
      end
      bmag_q   <= '0;
      bvalid_q <= 1'b0;
      sum_q    <= '0;
    end else begin
      if (accept && !op_i) begin
        bp_q[0] <= pos_x_i;
        bp_q[1] <= pos_y_i;
        bp_q[2] <= pos_z_i;
        bv_q[0] <= vec_x_i;
        bv_q[1] <= vec_y_i;
        bv_q[2] <= vec_z_i;
        sum_q   <= '0;
      end
      if ((state_q == ppvf_pkg::ST_B_RT) && sq_done) begin
        bmag_q   <= root[31:0];
        bvalid_q <= (root[31:0] != '0) && (root[31:0] >= min_area_q);
      end
      if (out_load) begin
        sum_q <= sum_new;
      end
    end
  end

  // item latch and intermediates
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      vec_q[0] <= vec_x_i;
      vec_q[1] <= vec_y_i;
      vec_q[2] <= vec_z_i;
      area_q   <= patch_area_i;
      occl_q   <= occluded_i;
      idx_q    <= patch_index_i;
      f_q      <= '0;
    end
    if ((state_q == ppvf_pkg::ST_P_R2) && mac_done && (k_q == 2'd2)) begin
      r2_q <= acc[ppvf_pkg::MAG_W-1:0];
    end
    if ((state_q == ppvf_pkg::ST_P_RT) && sq_done) begin
      rmag_q <= root;
    end
    if ((state_q == ppvf_pkg::ST_P_DA) && mac_done && (k_q == 2'd2)) begin
      da_q <= acc_mag;
    end
    if ((state_q == ppvf_pkg::ST_P_DB) && mac_done && (k_q == 2'd2)) begin
      db_q <= acc_mag;
    end
    if (((state_q == ppvf_pkg::ST_P_M1) || (state_q == ppvf_pkg::ST_P_M3)) && mac_done) begin
      den_q <= acc[ppvf_pkg::DEN_W-1:0];
    end
    if ((state_q == ppvf_pkg::ST_P_M2) && mac_done) begin
      t_q <= acc[ppvf_pkg::T_W-1:0];
    end
    if (state_q == ppvf_pkg::ST_P_D1) begin
      if (!launched_q && ovf1) begin
        cosi_q <= ppvf_pkg::COS_ONE;
      end else if (dv_done) begin
        cosi_q <= (q > ppvf_pkg::Q_W'(ppvf_pkg::COS_ONE)) ? ppvf_pkg::COS_ONE : q[28:0];
      end
    end
    if (state_q == ppvf_pkg::ST_P_D2) begin
      if (!launched_q && ovf2) begin
        gv_q <= ppvf_pkg::GV_ONE;
      end else if (dv_done) begin
        gv_q <= (q > ppvf_pkg::GV_ONE) ? ppvf_pkg::GV_ONE : q;
      end
    end
    if ((state_q == ppvf_pkg::ST_P_M4) && mac_done) begin
      f_q <= (acc[ppvf_pkg::ACC_W-1:60] != '0) ? 32'hFFFF_FFFF : acc[59:28];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      view_factor_o <= f_q;
      contributes_o <= (f_q != '0);
      index_out_o   <= op_q ? idx_q : '0;
      view_sum_o    <= sum_new;
    end
  end

  ppvf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  ppvf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .n_i     (acc[ppvf_pkg::MAG_W-1:0]),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  ppvf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .rem_i   (dv_rem),
    .low_i   (dv_low),
    .steps_i (dv_steps),
    .d_i     (den_q),
    .busy_o  (dv_busy),
    .q_o     (q)
  );

endmodule

// ----- rtl/ppvf_mac.sv -----
`timescale 1ns / 1ps
// bit-serial multiply accumulate: one multiplier bit per cycle
// depends on ppvf_pkg
module ppvf_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ppvf_pkg::mac_ctl_t             ctl_i,
  input  logic [ppvf_pkg::MAG_W-1:0]     a_i,
  input  logic [ppvf_pkg::MAG_W-1:0]     b_i,
  output logic                           busy_o,
  output logic [ppvf_pkg::ACC_W-1:0]     acc_o
);

  logic                       busy_q;
  logic [ppvf_pkg::ACC_W-1:0] a_q;
  logic [ppvf_pkg::MAG_W-1:0] b_q;
  logic                       neg_q;
  logic [ppvf_pkg::ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
    end else if (busy_q && (b_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q   <= ppvf_pkg::ACC_W'(a_i);
      b_q   <= b_i;
      neg_q <= ctl_i.neg;
      if (ctl_i.clear) begin
        acc_q <= '0;
      end
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= neg_q ? acc_q - a_q : acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule

// ----- rtl/ppvf_sqrt.sv -----
`timescale 1ns / 1ps
// floor square root, one result bit per cycle
// depends on ppvf_pkg
module ppvf_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ppvf_pkg::MAG_W-1:0]    n_i,
  output logic                          busy_o,
  output logic [ppvf_pkg::RT_W-1:0]     root_o
);

  logic [ppvf_pkg::STEP_W-1:0] cnt_q;
  logic [2*ppvf_pkg::RT_W-1:0] n_q;
  logic [ppvf_pkg::RT_W+1:0]   rem_q;
  logic [ppvf_pkg::RT_W-1:0]   root_q;
  logic [ppvf_pkg::RT_W+3:0]   rem2;
  logic [ppvf_pkg::RT_W+3:0]   trial;

  assign rem2  = {rem_q, n_q[2*ppvf_pkg::RT_W-1 -: 2]};
  assign trial = (ppvf_pkg::RT_W+4)'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= ppvf_pkg::STEP_W'(ppvf_pkg::RT_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= (2*ppvf_pkg::RT_W)'(n_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      n_q <= n_q << 2;
      if (rem2 >= trial) begin
        rem_q  <= (ppvf_pkg::RT_W+2)'(rem2 - trial);
        root_q <= {root_q[ppvf_pkg::RT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem2[ppvf_pkg::RT_W+1:0];
        root_q <= {root_q[ppvf_pkg::RT_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

endmodule

// ----- rtl/ppvf_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, partial remainder preloaded
// depends on ppvf_pkg
module ppvf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ppvf_pkg::DEN_W-1:0]    rem_i,
  input  logic [ppvf_pkg::Q_W-1:0]      low_i,
  input  logic [ppvf_pkg::STEP_W-1:0]   steps_i,
  input  logic [ppvf_pkg::DEN_W-1:0]    d_i,
  output logic                          busy_o,
  output logic [ppvf_pkg::Q_W-1:0]      q_o
);

  logic [ppvf_pkg::STEP_W-1:0] cnt_q;
  logic [ppvf_pkg::DEN_W-1:0]  rem_q;
  logic [ppvf_pkg::DEN_W-1:0]  d_q;
  logic [ppvf_pkg::Q_W-1:0]    low_q;
  logic [ppvf_pkg::Q_W-1:0]    q_q;
  logic [ppvf_pkg::DEN_W:0]    rem2;
  logic                        fits;

  assign rem2 = {rem_q, low_q[ppvf_pkg::Q_W-1]};
  assign fits = (rem2 >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= steps_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      low_q <= low_i;
      d_q   <= d_i;
      q_q   <= '0;
    end else if (cnt_q != '0) begin
      low_q <= low_q << 1;
      q_q   <= {q_q[ppvf_pkg::Q_W-2:0], fits};
      if (fits) begin
        rem_q <= ppvf_pkg::DEN_W'(rem2 - {1'b0, d_q});
      end else begin
        rem_q <= rem2[ppvf_pkg::DEN_W-1:0];
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign q_o    = q_q;

endmodule

// ----- bench/tb_point_patch_view_factor_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for point_patch_view_factor_top: directed and random items
// are predicted bit-exactly and compared; depends on ppvf_pkg and the block's rtl
module tb_point_patch_view_factor_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 700;
  localparam logic [127:0] INV_PI_W = 128'd1367130551;

  typedef struct {
    bit              op;
    logic [31:0]     pos [3];
    logic [31:0]     vec [3];
    logic [31:0]     area;
    bit              occl;
    logic [19:0]     idx;
  } item_t;

  typedef struct {
    logic [31:0] vf;
    bit          contrib;
    logic [19:0] idx;
    logic [39:0] sum;
  } factor_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i, in_stall_o, op_i, occluded_i;
  logic [31:0] pos_x_i, pos_y_i, pos_z_i, vec_x_i, vec_y_i, vec_z_i, patch_area_i;
  logic [ppvf_pkg::INDEX_BITS-1:0] patch_index_i, index_out_o;
  logic out_valid_o, out_stall_i, contributes_o;
  logic [31:0] view_factor_o;
  logic [39:0] view_sum_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [ppvf_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  point_patch_view_factor_top DUT (.*);

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  // predictor state
  logic signed [31:0] body_pos [3];
  logic signed [31:0] body_vec [3];
  logic [31:0] body_mag;
  bit          body_ok;
  logic [39:0] running_sum;
  logic [30:0] lim_reg;
  bit          lim_en;
  logic [31:0] area_floor;

  factor_t expected_factors [$];
  int  errors = 0;
  bit  quiet = 0;
  bit  hold_out = 0;
  int  stall_count = 0;

  function automatic logic [127:0] floor_sqrt(logic [127:0] n);
    logic [127:0] res, c;
    res = 0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (128'd1 << b);
      if (c * c <= n) res = c;
    end
    return res;
  endfunction

  function automatic factor_t predict_factor(item_t it);
    factor_t f;
    logic signed [127:0] rw [3];
    logic signed [127:0] dot_a, dot_b, t;
    logic [127:0] sq, r2, da, db, rmag, ci, cosi, g, gv, fw, fv, nsum;
    bit ok;
    f = '{default: 0};
    if (!it.op) begin
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        body_pos[i] = it.pos[i];
        body_vec[i] = it.vec[i];
        t = $signed(it.vec[i]);
        sq += $unsigned(t * t);
      end
      body_mag = 32'(floor_sqrt(sq));
      body_ok = body_mag != 0 && body_mag >= area_floor;
      running_sum = 0;
      return f;
    end
    r2 = 0; dot_a = 0; dot_b = 0;
    for (int i = 0; i < 3; i++) begin
      rw[i] = $signed(body_pos[i]) - $signed(it.pos[i]);
      r2 += $unsigned(rw[i] * rw[i]);
      t = body_vec[i];
      dot_a += t * rw[i];
      t = $signed(it.vec[i]);
      dot_b += t * rw[i];
    end
    ok = body_ok && it.area >= area_floor && !it.occl && r2 != 0;
    if (ok && lim_en) ok = r2 < 128'(lim_reg) * 128'(lim_reg);
    // point must face the patch: A.r negative
    if (ok) ok = dot_a < 0;
    fv = 0;
    if (ok) begin
      da = $unsigned(-dot_a);
      db = dot_b < 0 ? $unsigned(-dot_b) : $unsigned(dot_b);
      rmag = floor_sqrt(r2);
      ci = (da << 28) / (128'(body_mag) * rmag);
      cosi = ci > (128'd1 << 28) ? (128'd1 << 28) : ci;
      g = ((db * INV_PI_W) << 8) / (r2 * rmag);
      gv = g > (128'd1 << 60) ? (128'd1 << 60) : g;
      fw = (cosi * gv) >> 28;
      fv = fw > 128'hFFFF_FFFF ? 128'hFFFF_FFFF : fw;
    end
    nsum = 128'(running_sum) + fv;
    running_sum = nsum > 128'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : nsum[39:0];
    f.vf = fv[31:0];
    f.contrib = fv != 0;
    f.idx = it.idx;
    f.sum = running_sum;
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    factor_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_factors.size() == 0) begin
        report_mismatch("unexpected result", 64'(view_factor_o), 64'd0);
      end else begin
        e = expected_factors.pop_front();
        if (view_factor_o !== e.vf) report_mismatch("view_factor", view_factor_o, e.vf);
        if (contributes_o !== e.contrib)
          report_mismatch("contributes", contributes_o, e.contrib);
        if (index_out_o !== e.idx) report_mismatch("index_out", index_out_o, e.idx);
        if (view_sum_o !== e.sum) report_mismatch("view_sum", view_sum_o, e.sum);
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_out) out_stall_i <= 1;
    else if (quiet) out_stall_i <= 0;
    else out_stall_i <= $urandom_range(0, 99) < 10;
  end

  // cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count == WATCHDOG_LIMIT) begin
      $display("FAIL point_patch_view_factor_top");
      $finish;
    end
  end

  task automatic send_item(item_t it);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1;
    op_i <= it.op;
    pos_x_i <= it.pos[0]; pos_y_i <= it.pos[1]; pos_z_i <= it.pos[2];
    vec_x_i <= it.vec[0]; vec_y_i <= it.vec[1]; vec_z_i <= it.vec[2];
    patch_area_i <= it.area;
    occluded_i <= it.occl;
    patch_index_i <= it.idx;
    do @(posedge clk_i); while (in_stall_o);
    expected_factors = {expected_factors, predict_factor(it)};
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (expected_factors.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [ppvf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == ppvf_pkg::REG_RANGE_LIMIT) lim_reg = data[30:0];
    else if (idx == ppvf_pkg::REG_RANGE_EN) lim_en = data[0];
    else if (idx == ppvf_pkg::REG_MIN_AREA) area_floor = data;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic item_t make_item(bit op, int px, int py, int pz,
                                      int vx, int vy, int vz);
    item_t it;
    it.op = op;
    it.pos[0] = px; it.pos[1] = py; it.pos[2] = pz;
    it.vec[0] = vx; it.vec[1] = vy; it.vec[2] = vz;
    it.area = 32'd4096;
    it.occl = 0;
    it.idx = 20'($urandom);
    return it;
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic item_t random_body();
    item_t it;
    int m;
    m = 1 << $urandom_range(4, 20);
    it = make_item(0, rand_span(1 << 22), rand_span(1 << 22), rand_span(1 << 22),
                   rand_span(m), rand_span(m), rand_span(m));
    return it;
  endfunction

  // patch near the current body point, random content
  function automatic item_t random_patch();
    item_t it;
    int m;
    m = 1 << $urandom_range(4, 24);
    it = make_item(1, body_pos[0] + rand_span(1 << 18), body_pos[1] + rand_span(1 << 18),
                   body_pos[2] + rand_span(1 << 18), rand_span(m), rand_span(m), rand_span(m));
    it.area = $urandom_range(0, 99) < 10 ? $urandom_range(0, 3) : $urandom_range(1, 1 << 16);
    it.occl = $urandom_range(0, 7) == 0;
    return it;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.op = 1'($urandom);
    for (int i = 0; i < 3; i++) begin
      it.pos[i] = $urandom;
      it.vec[i] = $urandom;
    end
    it.area = $urandom;
    it.occl = 1'($urandom);
    it.idx = 20'($urandom);
    return it;
  endfunction

  task automatic test_directed();
    item_t it;
    send_item(make_item(1, 0, 0, 0, 4096, 0, 0));            // body never loaded
    send_item(make_item(0, 0, 0, 0, 0, 0, 0));               // zero body vector
    send_item(make_item(1, 4096, 0, 0, -4096, 0, 0));
    send_item(make_item(0, 0, 0, 0, 4096, 0, 0));
    send_item(make_item(1, 0, 0, 0, -4096, 0, 0));           // patch on the point
    send_item(make_item(1, -4096, 0, 0, 4096, 0, 0));        // faces away
    it = make_item(1, 4096, 0, 0, -4096, 0, 0);
    send_item(it);                                           // plain hit
    it.occl = 1;
    send_item(it);
    it.occl = 0; it.area = 0;
    send_item(it);                                           // area below floor
    it.area = 32'hFFFF_FFFF; it.idx = 20'hFFFFF;
    send_item(it);
    send_item(make_item(1, 409600, 0, 0, -4096, 0, 0));      // exactly at range
    send_item(make_item(1, 409599, 0, 0, -4096, 0, 0));
    send_item(make_item(1, 8192, 4096, -4096, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    send_item(make_item(1, 1, 0, 0, 32'h8000_0000, 0, 0));   // huge factor, saturates
    send_item(make_item(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(make_item(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(make_item(0, 100, -200, 300, 0, 1, 0));        // tiny body vector
    send_item(make_item(1, 100, 4000, 300, 0, -4096, 0));
    wait_idle();
  endtask

  task automatic test_range_extremes();
    write_reg(ppvf_pkg::REG_RANGE_EN, 32'd0);
    write_reg(ppvf_pkg::REG_MIN_AREA, 32'd0);
    send_item(make_item(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 4096, 4096, 4096));
    send_item(make_item(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -4096, 0, 0));
    send_item(make_item(0, 0, 0, 0, 0, 0, 0));               // zero vector with floor zero
    send_item(make_item(1, 4096, 0, 0, -4096, 0, 0));
    wait_idle();
    write_reg(ppvf_pkg::REG_RANGE_EN, 32'd1);
    write_reg(ppvf_pkg::REG_RANGE_LIMIT, 32'd0);
    send_item(make_item(0, 0, 0, 0, 4096, 0, 0));
    send_item(make_item(1, 1, 0, 0, -4096, 0, 0));
    wait_idle();
    write_reg(ppvf_pkg::REG_RANGE_LIMIT, 32'h7FFF_FFFF);
    write_reg(ppvf_pkg::REG_MIN_AREA, 32'hFFFF_FFFF);
    send_item(make_item(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(make_item(1, 32'h7FFF_FFFF, 5, 5, 1, 1, 1));
    wait_idle();
  endtask

  task automatic test_sum_saturation();
    item_t it;
    write_reg(ppvf_pkg::REG_RANGE_LIMIT, 32'd409600);
    write_reg(ppvf_pkg::REG_RANGE_EN, 32'd1);
    write_reg(ppvf_pkg::REG_MIN_AREA, 32'd1);
    quiet = 1;
    send_item(make_item(0, 0, 0, 0, 4096, 0, 0));
    repeat (270) begin
      it = make_item(1, 4096, 0, 0, 1 << 30, 0, 0);
      send_item(it);
    end
    quiet = 0;
    wait_idle();
  endtask

  task automatic test_random(int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 99) < 8) send_item(noise_item());
      else if ($urandom_range(0, 99) < 6) send_item(random_body());
      else send_item(random_patch());
      k++;
    end
    wait_idle();
  endtask

  task automatic test_output_hold();
    fork
      begin
        @(posedge clk_i);
        hold_out = 1;
        repeat (400) @(posedge clk_i);
        hold_out = 0;
      end
    join_none
    send_item(random_body());
    repeat (10) send_item(random_patch());
    wait_idle();
  endtask

  initial begin
    in_valid_i = 0; op_i = 0; occluded_i = 0;
    pos_x_i = 0; pos_y_i = 0; pos_z_i = 0;
    vec_x_i = 0; vec_y_i = 0; vec_z_i = 0;
    patch_area_i = 0; patch_index_i = 0;
    out_stall_i = 0;
    cfg_valid_i = 0; cfg_index_i = ppvf_pkg::REG_RANGE_LIMIT; cfg_data_i = 0;
    body_pos = '{0, 0, 0}; body_vec = '{0, 0, 0};
    body_mag = 0; body_ok = 0; running_sum = 0;
    lim_reg = 31'd409600; lim_en = 1; area_floor = 1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    test_directed();
    test_range_extremes();
    test_sum_saturation();
    write_reg(ppvf_pkg::REG_RANGE_LIMIT, 32'd409600);
    write_reg(ppvf_pkg::REG_RANGE_EN, 32'd1);
    write_reg(ppvf_pkg::REG_MIN_AREA, 32'd1);
    test_random(500);
    quiet = 1;
    test_random(150);
    quiet = 0;
    write_reg(ppvf_pkg::REG_RANGE_EN, 32'd0);
    write_reg(ppvf_pkg::REG_MIN_AREA, 32'd0);
    test_random(350);
    write_reg(ppvf_pkg::REG_RANGE_EN, 32'd1);
    write_reg(ppvf_pkg::REG_RANGE_LIMIT, 32'd200000);
    write_reg(ppvf_pkg::REG_MIN_AREA, 32'd2000);
    test_random(350);
    test_output_hold();

    if (errors == 0) begin
      $display("PASS point_patch_view_factor_top");
    end else begin
      $display("FAIL point_patch_view_factor_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ppvf_pkg.sv
rtl/ppvf_mac.sv
rtl/ppvf_sqrt.sv
rtl/ppvf_div.sv
rtl/point_patch_view_factor_top.sv
bench/tb_point_patch_view_factor_top.sv
